FILE: hw/rtl/dpiq_pkg.sv
// ----------------------------------------------------------------------------
// dpiq_pkg
// Shared constants and types of the depth pixel inverse quantizer.
// ----------------------------------------------------------------------------
package dpiq_pkg;

  // Fixed widths of the numerator path, the codes and the registers.
  localparam int unsigned NUM_W  = 32;
  localparam int unsigned CODE_W = 16;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned FH_W   = 13;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned IDX_W  = 2;

  // Register indexes, taken from paddr[3:2].
  localparam logic [IDX_W-1:0] REG_Z_MIN        = 2'd0;
  localparam logic [IDX_W-1:0] REG_Z_MAX        = 2'd1;
  localparam logic [IDX_W-1:0] REG_MAX_CODE     = 2'd2;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd3;

  // Register values after reset.
  localparam logic [CFG_W-1:0] RST_Z_MIN        = 16'd300;
  localparam logic [CFG_W-1:0] RST_Z_MAX        = 16'd4000;
  localparam logic [CFG_W-1:0] RST_MAX_CODE     = 16'd2046;
  localparam logic [FH_W-1:0]  RST_FRAME_HEIGHT = 13'd480;

  // Sequencer states of the coefficient unit.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL1 = 5'b00010,
    S_MUL2 = 5'b00100,
    S_DIVA = 5'b01000,
    S_DIVB = 5'b10000
  } coef_state_e;

  // Status and results of the coefficient unit.
  typedef struct packed {
    logic             busy;
    logic [NUM_W-1:0] scale;
    logic [NUM_W-1:0] offset;
  } coef_t;

endpackage

FILE: hw/rtl/dpiq_cell.sv
// ----------------------------------------------------------------------------
// dpiq_cell
// One stage of the divider chain: settles one quotient bit per beat.
// ----------------------------------------------------------------------------
module dpiq_cell #(
  parameter int unsigned Z_W    = 16,
  parameter int unsigned SIDE_W = 25
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [Z_W-1:0]             z_i,
  input  logic [Z_W-1:0]             rem_i,
  input  logic [dpiq_pkg::NUM_W-1:0] work_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [Z_W-1:0]             z_o,
  output logic [Z_W-1:0]             rem_o,
  output logic [dpiq_pkg::NUM_W-1:0] work_o,
  output logic [SIDE_W-1:0]          side_o
);
  import dpiq_pkg::*;

  logic             valid_q;
  logic [Z_W-1:0]   z_q;
  logic [Z_W-1:0]   rem_q, rem_d;
  logic [NUM_W-1:0] work_q, work_d;
  logic [SIDE_W-1:0] side_q;
  logic [Z_W:0]     shifted;
  logic             ge;

  // Restoring step: bring down the next numerator bit and try to subtract.
  // The work word shifts the numerator out at the top and the quotient in
  // at the bottom.
  always_comb begin
    shifted = {rem_i, work_i[NUM_W-1]};
    ge      = (shifted >= {1'b0, z_i});
    rem_d   = ge ? Z_W'(shifted - {1'b0, z_i}) : Z_W'(shifted);
    work_d  = {work_i[NUM_W-2:0], ge};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      z_q    <= z_i;
      rem_q  <= rem_d;
      work_q <= work_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign z_o     = z_q;
  assign rem_o   = rem_q;
  assign work_o  = work_q;
  assign side_o  = side_q;

endmodule

FILE: hw/rtl/dpiq_coef.sv
// ----------------------------------------------------------------------------
// dpiq_coef
// Derives the scale numerator and the code offset from the depth window.
// ----------------------------------------------------------------------------
module dpiq_coef (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [dpiq_pkg::CFG_W-1:0] z_min_i,
  input  logic [dpiq_pkg::CFG_W-1:0] z_max_i,
  input  logic [dpiq_pkg::CFG_W-1:0] max_code_i,
  output dpiq_pkg::coef_t            coef_o
);
  import dpiq_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W);

  coef_state_e      state_q, state_d;
  logic [NUM_W-1:0] prod_q;
  logic [CFG_W-1:0] span_q;
  logic             empty_q;
  logic [CFG_W-1:0] rem_q;
  logic [NUM_W-1:0] quot_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] scale_q;
  logic [NUM_W-1:0] offset_q;
  logic [CFG_W:0]   shifted;
  logic             ge;
  logic [CFG_W-1:0] rem_n;
  logic [NUM_W-1:0] quot_n;
  logic             last;

  // One quotient bit per cycle, shared by both divisions.
  always_comb begin
    shifted = {rem_q, quot_q[NUM_W-1]};
    ge      = (shifted >= {1'b0, span_q});
    rem_n   = ge ? CFG_W'(shifted - {1'b0, span_q}) : CFG_W'(shifted);
    quot_n  = {quot_q[NUM_W-2:0], ge};
    last    = (cnt_q == CNT_W'(NUM_W - 1));
  end

  always_comb begin
    state_d = state_q;
    if (start_i) begin
      state_d = S_MUL1;
    end else begin
      unique case (state_q)
        S_IDLE: state_d = S_IDLE;
        S_MUL1: state_d = S_MUL2;
        S_MUL2: state_d = empty_q ? S_IDLE : S_DIVA;
        S_DIVA: state_d = last ? S_DIVB : S_DIVA;
        S_DIVB: state_d = last ? S_IDLE : S_DIVB;
        default: state_d = S_IDLE;
      endcase
    end
  end

  // The sequencer comes out of reset working, so the reset window is
  // reflected in the coefficients before the first beat is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_MUL1;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DIVA || state_q == S_DIVB) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= '0;
      offset_q <= '0;
    end else if (!start_i) begin
      if (state_q == S_MUL2 && empty_q) begin
        scale_q  <= '0;
        offset_q <= '0;
      end
      if (state_q == S_DIVA && last) begin
        scale_q <= quot_n;
      end
      if (state_q == S_DIVB && last) begin
        offset_q <= NUM_W'(NUM_W'(max_code_i) + quot_n);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_MUL1: begin
        prod_q  <= NUM_W'(max_code_i) * NUM_W'(z_min_i);
        span_q  <= CFG_W'(z_max_i - z_min_i);
        empty_q <= (z_min_i >= z_max_i);
      end
      S_MUL2: begin
        // Product of all three, kept modulo 2^32.
        quot_q <= NUM_W'(prod_q * NUM_W'(z_max_i));
        rem_q  <= '0;
      end
      S_DIVA: begin
        if (last) begin
          quot_q <= prod_q;
          rem_q  <= '0;
        end else begin
          quot_q <= quot_n;
          rem_q  <= rem_n;
        end
      end
      S_DIVB: begin
        quot_q <= quot_n;
        rem_q  <= rem_n;
      end
      default: begin
        quot_q <= quot_q;
      end
    endcase
  end

  assign coef_o.busy   = (state_q != S_IDLE);
  assign coef_o.scale  = scale_q;
  assign coef_o.offset = offset_q;

endmodule

FILE: hw/rtl/depth_pixel_inverse_quantizer.sv
// ----------------------------------------------------------------------------
// depth_pixel_inverse_quantizer
// Maps raw depth samples to inverse-depth codes and flips the row.
// ----------------------------------------------------------------------------
// The block takes one sample beat per clock while s_axis_tready is high and
// returns one result beat for each, in order, through the divider chain and
// then the output register. The chain has 32 cells, each settling one bit of
// the quotient a/z. After reset and after every write to z_min, z_max or
// max_code, s_axis_tready stays low while a and b are recomputed by a shared
// bit-per-clock divider (the divisions are skipped when z_min >= z_max);
// frame_height writes take effect at once.
module depth_pixel_inverse_quantizer #(
  parameter int unsigned RAW_BITS   = 16,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // raw_depth, pixel_column, pixel_row (from bit 0 up), zero-padded to bytes
  input  logic [((RAW_BITS+2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // depth_code, out_column, out_row (from bit 0 up), zero-padded to bytes
  output logic [((dpiq_pkg::CODE_W+2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  // depth_valid
  output logic                        m_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dpiq_pkg::ADDR_W-1:0] paddr,
  input  logic [dpiq_pkg::DATA_W-1:0] pwdata,
  output logic [dpiq_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import dpiq_pkg::*;

  localparam int unsigned OUT_W  = CODE_W + 2*COORD_BITS;
  localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8;
  localparam int unsigned SIDE_W = 1 + 2*COORD_BITS;
  localparam int unsigned ROW_W  = ((COORD_BITS > FH_W) ? COORD_BITS : FH_W) + 1;

  // ---------------------------------------------------------------- registers
  logic [CFG_W-1:0] z_min_q, z_max_q, max_code_q;
  logic [FH_W-1:0]  frame_height_q;
  logic             wr;
  logic [IDX_W-1:0] idx;
  logic             coef_start;
  coef_t            coef;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z_min_q        <= RST_Z_MIN;
      z_max_q        <= RST_Z_MAX;
      max_code_q     <= RST_MAX_CODE;
      frame_height_q <= RST_FRAME_HEIGHT;
    end else if (wr) begin
      unique case (idx)
        REG_Z_MIN:        z_min_q        <= pwdata[CFG_W-1:0];
        REG_Z_MAX:        z_max_q        <= pwdata[CFG_W-1:0];
        REG_MAX_CODE:     max_code_q     <= pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= pwdata[FH_W-1:0];
        default:          z_min_q        <= z_min_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_Z_MIN:        prdata = DATA_W'(z_min_q);
      REG_Z_MAX:        prdata = DATA_W'(z_max_q);
      REG_MAX_CODE:     prdata = DATA_W'(max_code_q);
      REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_q);
      default:          prdata = '0;
    endcase
  end

  assign coef_start = wr && (idx != REG_FRAME_HEIGHT);

  dpiq_coef u_coef (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (coef_start),
    .z_min_i    (z_min_q),
    .z_max_i    (z_max_q),
    .max_code_i (max_code_q),
    .coef_o     (coef)
  );

  // -------------------------------------------------------------- front end
  logic [RAW_BITS-1:0]   raw_depth;
  logic [COORD_BITS-1:0] pixel_column, pixel_row;
  logic [CFG_W-1:0]      z_ext;
  logic                  bad;
  logic [ROW_W-1:0]      row_x, fh_x;
  logic [COORD_BITS-1:0] row_flip;

  assign raw_depth    = s_axis_tdata[RAW_BITS-1:0];
  assign pixel_column = s_axis_tdata[RAW_BITS +: COORD_BITS];
  assign pixel_row    = s_axis_tdata[RAW_BITS+COORD_BITS +: COORD_BITS];

  always_comb begin
    z_ext    = CFG_W'(raw_depth);
    bad      = (raw_depth == '0) || (z_min_q >= z_max_q) ||
               (z_ext < z_min_q) || (z_ext > z_max_q);
    row_x    = ROW_W'(pixel_row);
    fh_x     = ROW_W'(frame_height_q);
    row_flip = (row_x >= fh_x) ? '0 : COORD_BITS'(fh_x - row_x - 1'b1);
  end

  // ---------------------------------------------------------- divider chain
  logic                  cv   [0:NUM_W];
  logic                  crdy [0:NUM_W];
  logic [RAW_BITS-1:0]   cz   [0:NUM_W];
  logic [RAW_BITS-1:0]   crem [0:NUM_W];
  logic [NUM_W-1:0]      cwrk [0:NUM_W];
  logic [SIDE_W-1:0]     cside[0:NUM_W];

  assign cv[0]    = s_axis_tvalid && !coef.busy;
  assign cz[0]    = raw_depth;
  assign crem[0]  = '0;
  assign cwrk[0]  = coef.scale;
  assign cside[0] = {row_flip, pixel_column, bad};
  assign s_axis_tready = crdy[0] && !coef.busy;

  for (genvar k = 0; k < NUM_W; k++) begin : g_cell
    dpiq_cell #(
      .Z_W    (RAW_BITS),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[k]),
      .ready_o (crdy[k]),
      .z_i     (cz[k]),
      .rem_i   (crem[k]),
      .work_i  (cwrk[k]),
      .side_i  (cside[k]),
      .valid_o (cv[k+1]),
      .ready_i (crdy[k+1]),
      .z_o     (cz[k+1]),
      .rem_o   (crem[k+1]),
      .work_o  (cwrk[k+1]),
      .side_o  (cside[k+1])
    );
  end

  // ------------------------------------------------------- output register
  logic                  out_valid_q;
  logic [CODE_W-1:0]     code_q, code_d;
  logic                  dvalid_q;
  logic [COORD_BITS-1:0] col_q, row_q;
  logic                  last_bad;

  assign last_bad  = cside[NUM_W][0];
  assign crdy[NUM_W] = !out_valid_q || m_axis_tready;

  // Only the low half of b - a/z survives, so the subtract stays narrow.
  assign code_d = last_bad ? CODE_W'(max_code_q + 1'b1)
                           : CODE_W'(coef.offset[CODE_W-1:0] - cwrk[NUM_W][CODE_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (crdy[NUM_W]) begin
      out_valid_q <= cv[NUM_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (crdy[NUM_W] && cv[NUM_W]) begin
      code_q   <= code_d;
      dvalid_q <= !last_bad;
      col_q    <= cside[NUM_W][1 +: COORD_BITS];
      row_q    <= cside[NUM_W][1+COORD_BITS +: COORD_BITS];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = dvalid_q;
  assign m_axis_tdata  = OUT_TW'({row_q, col_q, code_q});

endmodule

FILE: hw/rtl/dpiq_checker.sv
// ----------------------------------------------------------------------------
// dpiq_checker
// Port-level checks of the depth pixel inverse quantizer.
// ----------------------------------------------------------------------------
module dpiq_checker #(
  parameter int unsigned RAW_BITS   = 16,
  parameter int unsigned COORD_BITS = 12
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic [((RAW_BITS+2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [((dpiq_pkg::CODE_W+2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  input logic                        m_axis_tuser,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [dpiq_pkg::ADDR_W-1:0] paddr,
  input logic [dpiq_pkg::DATA_W-1:0] pwdata,
  input logic [dpiq_pkg::DATA_W-1:0] prdata,
  input logic                        pready
);
  import dpiq_pkg::*;

  logic             wr;
  logic [CFG_W-1:0] max_code_q;

  assign wr = psel && penable && pwrite && pready;

  // Mirror of max_code as written over the register port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_code_q <= RST_MAX_CODE;
    end else if (wr && paddr[ADDR_W-1:2] == REG_MAX_CODE) begin
      max_code_q <= pwdata[CFG_W-1:0];
    end
  end

  // A result beat held off by the sink stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat withdrawn while stalled");

  // A write that changes the window must stop intake while a and b are rebuilt.
  a_coef_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr && (paddr[ADDR_W-1:2] != REG_FRAME_HEIGHT) |=> !s_axis_tready)
    else $error("samples taken while coefficients are stale");

  // A rejected sample must carry the invalid code.
  a_invalid_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      m_axis_tdata[CODE_W-1:0] == CODE_W'(max_code_q + 1'b1))
    else $error("invalid sample without invalid code");

  // The ports not used by the checks above are listed here so nothing hangs.
  logic unused_ok;
  assign unused_ok = ^{s_axis_tdata, s_axis_tvalid, prdata};

endmodule

bind depth_pixel_inverse_quantizer dpiq_checker #(
  .RAW_BITS   (RAW_BITS),
  .COORD_BITS (COORD_BITS)
) u_dpiq_checker (.*);
